### src/sdst_pkg.sv
// Shared types and constants for the sparse disk sector translation block.
package sdst_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int SECTOR_W     = 55;
	localparam int SECTOR_SHIFT = 9;
	localparam int DIVIDEND_W   = SECTOR_W + SECTOR_SHIFT;
	localparam int DIVISOR_W    = 32;
	localparam int STEP_W       = $clog2(DIVIDEND_W);

	localparam int ENTRY_W      = 32;
	localparam int BMP_OFF_W    = ENTRY_W + SECTOR_SHIFT;
	localparam int FILE_OFF_W   = 42;
	localparam int BITMAP_W     = 21;
	localparam int LIMIT_W      = 13;

	localparam logic [ENTRY_W-1:0] UNALLOC_ENTRY = '1;

	localparam logic [DIVISOR_W-1:0] BLOCK_BYTES_RST  = 32'd2097152;
	localparam logic [BITMAP_W-1:0]  BITMAP_BYTES_RST = 21'd512;
	localparam logic [LIMIT_W-1:0]   TABLE_LIMIT_RST  = 13'd0;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT  = 2'd2;

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quot;
		logic [DIVISOR_W-1:0]  rem;
	} div_res_t;

endpackage

### src/sparse_disk_sector_translate_top.sv
// Top level of the sparse disk sector translation block.
// Translates a 512-byte sector number of a sparse disk image to a file byte offset
// through a block table held in RAM. A translate word runs through the bit-serial
// divider (one quotient bit of the 64-bit byte offset per cycle) until the divide
// state sees it finish, then through the states for the table read, the offset sum
// and the result. A load word, or a translate with a block size of zero, goes from
// idle straight to the result state. One word is worked on at a time: in_stall is
// high while a word is in flight or its result cannot yet enter the output register.
// Table entries that were never loaded read back undefined. The configuration port is
// always ready.
module sparse_disk_sector_translate_top import sdst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [SECTOR_W-1:0]   sector,
	input  logic                  is_write,
	input  logic [11:0]           entry_index,
	input  logic [ENTRY_W-1:0]    entry_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  allocated,
	output logic [FILE_OFF_W-1:0] file_offset,
	output logic                  bitmap_write,
	output logic [BMP_OFF_W-1:0]  bmp_offset
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LOOKUP,
		ST_CALC,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [DIVISOR_W-1:0] block_bytes_q;
	logic [BITMAP_W-1:0]  bitmap_bytes_q;
	logic [LIMIT_W-1:0]   table_limit_q;

	logic                  is_write_q;
	logic                  in_range_q;
	logic                  alloc_q;
	logic [BMP_OFF_W-1:0]  bmp_off_q;
	logic [FILE_OFF_W-1:0] base_sum_q;
	logic [BMP_OFF_W-1:0]  last_bmp_q;

	logic                  out_valid_q;
	logic                  allocated_q;
	logic [FILE_OFF_W-1:0] file_offset_q;
	logic                  bitmap_write_q;
	logic [BMP_OFF_W-1:0]  bmp_offset_q;

	div_req_t div_req;
	div_res_t div_res;

	logic                  accept;
	logic                  out_free;
	logic                  ram_we;
	logic                  ram_re;
	logic [TABLE_AW-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [DIVIDEND_W-1:0] limit_w;
	logic                  in_range;
	logic [BMP_OFF_W-1:0]  bmp_off;
	logic [FILE_OFF_W-1:0] data_off;
	logic                  new_bitmap;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q  <= BLOCK_BYTES_RST;
			bitmap_bytes_q <= BITMAP_BYTES_RST;
			table_limit_q  <= TABLE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLOCK_BYTES:  block_bytes_q  <= cfg_data;
				REG_BITMAP_BYTES: bitmap_bytes_q <= cfg_data[BITMAP_W-1:0];
				REG_TABLE_LIMIT:  table_limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign div_req.start    = accept && (op == OP_TRANSLATE) && (block_bytes_q != '0);
	assign div_req.dividend = {sector, {SECTOR_SHIFT{1'b0}}};
	assign div_req.divisor  = block_bytes_q;

	sdst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// saturate the limit at the table depth, compare against the full quotient
	assign limit_w  = (DIVIDEND_W'(table_limit_q) > DIVIDEND_W'(TABLE_DEPTH)) ?
	                  DIVIDEND_W'(TABLE_DEPTH) : DIVIDEND_W'(table_limit_q);
	assign in_range = div_res.quot < limit_w;

	assign ram_we    = accept && (op == OP_LOAD) && (32'(entry_index) < 32'(TABLE_DEPTH));
	assign ram_re    = (state_q == ST_LOOKUP);
	assign ram_raddr = div_res.quot[TABLE_AW-1:0];

	sdst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (TABLE_AW'(entry_index)),
		.wdata (entry_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign bmp_off    = {ram_rdata, {SECTOR_SHIFT{1'b0}}};
	// sector in block times 512 is the remainder with its low bits cleared
	assign data_off   = base_sum_q + FILE_OFF_W'({div_res.rem[DIVISOR_W-1:SECTOR_SHIFT],
	                                            {SECTOR_SHIFT{1'b0}}});
	assign new_bitmap = alloc_q && is_write_q && (last_bmp_q != bmp_off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			is_write_q      <= 1'b0;
			in_range_q      <= 1'b0;
			alloc_q         <= 1'b0;
			bmp_off_q       <= '0;
			base_sum_q      <= '0;
			last_bmp_q      <= '1;
			out_valid_q     <= 1'b0;
			allocated_q     <= 1'b0;
			file_offset_q   <= '0;
			bitmap_write_q  <= 1'b0;
			bmp_offset_q    <= '0;
		end else begin
			// in the result state the output register is reloaded instead
			if (out_valid_q && !out_stall && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						is_write_q <= is_write;
						alloc_q    <= 1'b0;
						if (div_req.start) begin
							state_q <= ST_DIVIDE;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_DIVIDE: begin
					if (div_res.done) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					in_range_q <= in_range;
					state_q    <= ST_CALC;
				end
				ST_CALC: begin
					alloc_q    <= in_range_q && (ram_rdata != UNALLOC_ENTRY);
					bmp_off_q  <= bmp_off;
					base_sum_q <= FILE_OFF_W'(bmp_off) + FILE_OFF_W'(bitmap_bytes_q);
					state_q    <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						allocated_q     <= alloc_q;
						file_offset_q   <= alloc_q ? data_off : '0;
						bmp_offset_q    <= alloc_q ? bmp_off_q : '0;
						bitmap_write_q  <= new_bitmap;
						if (new_bitmap) begin
							last_bmp_q <= bmp_off_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign allocated     = allocated_q;
	assign file_offset   = file_offset_q;
	assign bitmap_write  = bitmap_write_q;
	assign bmp_offset    = bmp_offset_q;

`ifndef NO_ASSERTIONS
	a_bmp_write_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!bitmap_write || allocated))
		else $error("bitmap write flagged on an unallocated result");

	a_unalloc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !allocated) |-> (file_offset == '0 && bmp_offset == '0))
		else $error("unallocated result carries a nonzero offset");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide state");

	a_load_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_LOAD) |=> (state_q == ST_RESULT))
		else $error("load word did not go straight to the result state");
`endif

endmodule

### src/sdst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sdst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/sdst_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module sdst_div import sdst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  divisor_q;

	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;
	logic [DIVISOR_W-1:0]  rem_next;

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	assign trial    = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge       = trial >= {1'b0, divisor_q};
	assign diff     = trial - {1'b0, divisor_q};
	assign rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			quo_q     <= req.dividend;
			rem_q     <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

### tb/sparse_disk_sector_translate_top_test.sv
// Self-checking testbench for the sparse disk sector translation top level.
`timescale 1ns / 100ps

module sparse_disk_sector_translate_top_test import sdst_pkg::*;;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic                  op;
		logic [SECTOR_W-1:0]   sector;
		logic                  is_write;
		logic [11:0]           entry_index;
		logic [ENTRY_W-1:0]    entry_value;
	} word_t;

	typedef struct packed {
		logic                  allocated;
		logic [FILE_OFF_W-1:0] file_offset;
		logic                  bitmap_write;
		logic [BMP_OFF_W-1:0]  bmp_offset;
	} xlat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_TRANSLATE;
	logic [SECTOR_W-1:0]   sector = '0;
	logic                  is_write = 1'b0;
	logic [11:0]           entry_index = '0;
	logic [ENTRY_W-1:0]    entry_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  allocated;
	logic [FILE_OFF_W-1:0] file_offset;
	logic                  bitmap_write;
	logic [BMP_OFF_W-1:0]  bmp_offset;

	sparse_disk_sector_translate_top uut (.*);

	// shadow of the block's registers and state
	logic [31:0]          blk_bytes = BLOCK_BYTES_RST;
	logic [BITMAP_W-1:0]  bmp_bytes = BITMAP_BYTES_RST;
	logic [LIMIT_W-1:0]   tbl_limit = TABLE_LIMIT_RST;
	logic [ENTRY_W-1:0]   block_table [TABLE_DEPTH];
	logic [BMP_OFF_W-1:0] last_bmp = '1;

	// entries the stimulus has loaded, so no unloaded entry is ever looked up
	bit                   entry_loaded [TABLE_DEPTH];
	logic [31:0]          recent_vals [$];

	word_t word_queue [$];
	xlat_t expected_xlat [$];
	word_t next_word;
	xlat_t got_xlat;
	xlat_t want_xlat;
	int    words_issued = 0;
	int    results_seen = 0;
	int    mismatches = 0;
	int    cycle_count = 0;
	bit    steady = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic xlat_t translate_word(input word_t w);
		xlat_t                r;
		logic [63:0]          byte_off;
		logic [63:0]          quo;
		logic [63:0]          rem;
		logic [LIMIT_W-1:0]   lim;
		logic [ENTRY_W-1:0]   ent;
		logic [BMP_OFF_W-1:0] bmp;
		r = '0;
		if (w.op == OP_LOAD) begin
			block_table[w.entry_index] = w.entry_value;
			return r;
		end
		if (blk_bytes == 32'd0)
			return r;
		byte_off = {w.sector, 9'd0};
		quo = byte_off / {32'd0, blk_bytes};
		rem = byte_off % {32'd0, blk_bytes};
		lim = (tbl_limit > TABLE_DEPTH) ? LIMIT_W'(TABLE_DEPTH) : tbl_limit;
		if (quo >= 64'(lim))
			return r;
		ent = block_table[quo[TABLE_AW-1:0]];
		if (ent == UNALLOC_ENTRY)
			return r;
		bmp = {ent, 9'd0};
		r.allocated = 1'b1;
		r.bmp_offset = bmp;
		r.file_offset = FILE_OFF_W'(bmp) + FILE_OFF_W'(bmp_bytes) + {rem[FILE_OFF_W-1:9], 9'd0};
		if (w.is_write && last_bmp != bmp) begin
			last_bmp = bmp;
			r.bitmap_write = 1'b1;
		end
		return r;
	endfunction

	// driver: predicts on acceptance, then offers the next word or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_xlat.push_back(translate_word({op, sector, is_write, entry_index,
					entry_value}));
			if (!in_valid || !in_stall) begin
				if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
					next_word = word_queue.pop_front();
					in_valid <= 1'b1;
					op <= next_word.op;
					sector <= next_word.sector;
					is_write <= next_word.is_write;
					entry_index <= next_word.entry_index;
					entry_value <= next_word.entry_value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// monitor: compares each accepted result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got_xlat = '{allocated, file_offset, bitmap_write, bmp_offset};
				if (expected_xlat.size() == 0) begin
					$display("%0t: unexpected result word, expected none got 0x%0h", $time,
						got_xlat);
					mismatches++;
				end else begin
					want_xlat = expected_xlat.pop_front();
					check_field("allocated", 64'(want_xlat.allocated), 64'(got_xlat.allocated));
					check_field("file_offset", 64'(want_xlat.file_offset),
						64'(got_xlat.file_offset));
					check_field("bitmap_write", 64'(want_xlat.bitmap_write),
						64'(got_xlat.bitmap_write));
					check_field("bmp_offset", 64'(want_xlat.bmp_offset),
						64'(got_xlat.bmp_offset));
				end
				results_seen <= results_seen + 1;
			end
			out_stall <= !steady && ($urandom_range(99) < 33);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BLOCK_BYTES:  blk_bytes = data;
			REG_BITMAP_BYTES: bmp_bytes = data[BITMAP_W-1:0];
			REG_TABLE_LIMIT:  tbl_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] blk, input logic [31:0] bmp,
		input logic [31:0] lim);
		write_reg(REG_BLOCK_BYTES, blk);
		write_reg(REG_BITMAP_BYTES, bmp);
		write_reg(REG_TABLE_LIMIT, lim);
	endtask

	// hold the sender until every predicted word has come back
	task automatic drain();
		while (results_seen != words_issued)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_word(input word_t w);
		word_queue.push_back(w);
		words_issued++;
		if (w.op == OP_LOAD) begin
			entry_loaded[w.entry_index] = 1'b1;
			recent_vals.push_back(w.entry_value);
			if (recent_vals.size() > 8)
				void'(recent_vals.pop_front());
		end
	endtask

	task automatic load_entry(input logic [11:0] idx, input logic [31:0] val);
		push_word('{OP_LOAD, SECTOR_W'($urandom), 1'($urandom), idx, val});
	endtask

	function automatic logic [31:0] pick_entry();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return UNALLOC_ENTRY;
		if (roll < 25 && recent_vals.size() != 0)
			return recent_vals[$urandom_range(recent_vals.size() - 1)];
		return $urandom;
	endfunction

	function automatic int eff_limit();
		return (tbl_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_limit);
	endfunction

	// translate word; loads the entry first if the lookup would hit an unloaded one
	task automatic translate(input logic [SECTOR_W-1:0] sec, input logic wr);
		logic [63:0] q;
		if (blk_bytes != 32'd0) begin
			q = {sec, 9'd0} / {32'd0, blk_bytes};
			if (q < 64'(eff_limit()) && !entry_loaded[q[TABLE_AW-1:0]])
				load_entry(q[11:0], pick_entry());
		end
		push_word('{OP_TRANSLATE, sec, wr, 12'($urandom), 32'($urandom)});
	endtask

	task automatic random_words(input int n);
		int          roll;
		int          eff;
		logic [63:0] q;
		logic [63:0] byte_off;
		logic [63:0] sec;
		repeat (n) begin
			roll = $urandom_range(99);
			eff = eff_limit();
			if (roll < 15) begin
				if (eff != 0 && $urandom_range(3) != 0)
					load_entry(12'($urandom_range(eff - 1)), pick_entry());
				else
					load_entry(12'($urandom), pick_entry());
			end else if (roll < 85 && blk_bytes != 32'd0) begin
				q = 64'($urandom_range(eff + 1));
				if ($urandom_range(4) == 0)
					byte_off = q * blk_bytes + blk_bytes - 64'd1;
				else
					byte_off = q * blk_bytes + ({32'd0, $urandom} % blk_bytes);
				sec = byte_off >> 9;
				translate(sec[SECTOR_W-1:0], $urandom_range(9) < 6);
			end else begin
				sec = {$urandom, $urandom};
				translate(sec[SECTOR_W-1:0], 1'($urandom));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: limit of zero, nothing is allocated
		translate('0, 1'b1);
		translate('1, 1'b0);
		load_entry(12'd0, 32'd5);
		load_entry(12'hfff, UNALLOC_ENTRY);
		drain();

		// limit saturates at the table depth
		set_config(32'd4096, 32'd512, 32'd8191);
		load_entry(12'd1, 32'd0);
		translate(55'd8, 1'b1);
		translate(55'd15, 1'b1);
		translate(55'd9, 1'b0);
		load_entry(12'd2, UNALLOC_ENTRY);
		translate(55'd16, 1'b1);
		load_entry(12'd3, 32'hffff_fffe);
		translate(55'd31, 1'b1);
		load_entry(12'd4, 32'hffff_fffe);
		translate(55'd32, 1'b1);
		translate(55'(4095 * 8), 1'b1);
		translate(55'(4096 * 8), 1'b1);
		// quotient whose low bits alias a loaded entry
		translate((55'd1 << 40) | 55'd8, 1'b1);
		drain();

		write_reg(REG_BLOCK_BYTES, 32'd0);
		translate(55'd8, 1'b1);
		drain();

		// block size not a multiple of a sector, widest bitmap
		set_config(32'd1000, 32'h001f_ffff, 32'd4);
		write_reg(REG_SPARE, 32'hdead_beef);
		for (int s = 0; s < 5; s++)
			translate(55'(s), 1'b1);
		drain();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: set_config(32'd512, 32'd0, 32'd8191);
				1: set_config(32'hffff_ffff, 32'h001f_ffff, 32'd4096);
				2: set_config(512 * $urandom_range(1, 16), $urandom_range(0, 1048576),
					$urandom_range(1, 64));
				3: set_config($urandom_range(512, 20000), $urandom_range(0, 2097151),
					$urandom_range(1, 200));
				4: set_config(32'd0, $urandom_range(0, 4096), $urandom_range(0, 64));
				5: set_config($urandom, $urandom_range(0, 2097151), $urandom_range(0, 8191));
				default: set_config(32'd2097152, 32'd512, $urandom_range(1, 32));
			endcase
			steady = (p == 3);
			random_words((p == 4) ? 30 : 45);
			drain();
			steady = 1'b0;
		end

		repeat (80) @(posedge clk);
		if (expected_xlat.size() != 0) begin
			$display("%0t: %0d result words expected, none arrived", $time,
				expected_xlat.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
